FILE: rtl/pair_sum_search_stream_assert.svh
// assertion macros used by the rtl of the pair sum search block
`ifndef PAIR_SUM_SEARCH_STREAM_ASSERT_SVH
`define PAIR_SUM_SEARCH_STREAM_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pss_pkg.sv
// shared types and constants of the pair sum search block
`default_nettype none

package pss_pkg;

  localparam int VAL_W   = 32;
  localparam int WANT_W  = 33;
  localparam int IDX_W   = 6;
  localparam int IDX_MAX = 63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DECIDE
  } state_e;

  // control broadcast along the cell chain
  typedef struct packed {
    logic shift;
    logic cmp;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pss_if.sv
// valid/ready stream interfaces for items in and results out
`default_nettype none

interface pss_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface pss_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] first_index;
  logic [5:0] second_index;
  logic       overflow;

  modport source (output valid, output found, output first_index,
                  output second_index, output overflow, input ready);
  modport sink   (input valid, input found, input first_index,
                  input second_index, input overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/pair_sum_search_stream.sv
// top level of the streaming pair sum search block
//
// usage:
//   item_i carries one signed value per transfer, last marks the end of a set.
//   target_sum_i is loaded when target_sum_we_i is high; the user loads it only
//   while idle, unenforced. result_o carries at most one result per set: found
//   with the earlier and later positions, or found = 0 on the last value when no
//   pair turned up. overflow means a value of the set did not fit the store.
// timing:
//   each item passes accept, compare across the chain and decide, and the next
//   item is taken only after decide; this is set by the compare register in
//   each cell and the encode/update step that the next item depends on.
//   a result is loaded into the output register at the end of the decide step.
// reset:
//   target_sum returns to 0, the stored count and set flags clear, the output
//   register empties; the stored values themselves are not cleared.
// stalls:
//   the output register holds a waiting result while the next item is taken;
//   the decide step waits whenever the output register is full and not being
//   taken, whether or not a result is due, and input ready stays low meanwhile.
`default_nettype none

`include "pair_sum_search_stream_assert.svh"

module pair_sum_search_stream import pss_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  pss_in_if.sink                 item_i,
  pss_out_if.source              result_o,
  input  wire logic              target_sum_we_i,
  input  wire logic [VAL_W-1:0]  target_sum_i
);

  // count holds 0..STORE_DEPTH, cell index 0..STORE_DEPTH-1
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = $clog2(STORE_DEPTH);

  state_e state_q, state_d;

  logic [VAL_W-1:0]         target_q;
  logic [VAL_W-1:0]         value_q;
  logic                     last_q;
  logic signed [WANT_W-1:0] want_q;

  logic [CW-1:0] count_q, count_d;
  logic          reported_q, reported_d;
  logic          exceeded_q, exceeded_d;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [IDX_W-1:0] out_first_q, out_first_d;
  logic [IDX_W-1:0] out_second_q, out_second_d;
  logic             out_ovf_q, out_ovf_d;

  cell_ctrl_t ctrl;
  logic       out_free;
  logic       item_take;

  // the chain: cell 0 holds the newest stored value
  logic [VAL_W-1:0]       chain [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] match_vec;
  logic                   hit;
  logic [IW-1:0]          hit_idx;
  logic [CW-1:0]          hit_pos;

  function automatic logic [IDX_W-1:0] sat_idx(input logic [CW-1:0] p);
    if (32'(p) > 32'(IDX_MAX)) begin
      return IDX_W'(IDX_MAX);
    end
    return IDX_W'(p);
  endfunction

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] din;
    if (k == 0) begin : g_head
      assign din = value_q;
    end else begin : g_body
      assign din = chain[k-1];
    end

    pss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .live_i  (count_q > CW'(k)),
      .din_i   (din),
      .want_i  (want_q),
      .dout_o  (chain[k]),
      .match_o (match_vec[k])
    );
  end

  pss_prio_enc #(
    .N  (STORE_DEPTH),
    .IW (IW)
  ) u_enc (
    .vec_i (match_vec),
    .hit_o (hit),
    .idx_o (hit_idx)
  );

  // newest match sits at the lowest cell, its set position counts from the front
  assign hit_pos   = count_q - CW'(1) - CW'(hit_idx);
  assign out_free  = !out_valid_q || result_o.ready;
  assign item_take = item_i.valid && item_i.ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (target_sum_we_i) begin
      target_q <= target_sum_i;
    end
  end

  // captured item and its 33-bit wanted partner value
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      value_q <= item_i.value;
      last_q  <= item_i.last;
      want_q  <= $signed({target_q[VAL_W-1], target_q})
               - $signed({item_i.value[VAL_W-1], item_i.value});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      reported_q  <= 1'b0;
      exceeded_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      reported_q  <= reported_d;
      exceeded_q  <= exceeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
    out_ovf_q    <= out_ovf_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    reported_d   = reported_q;
    exceeded_d   = exceeded_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_found_d  = out_found_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    out_ovf_d    = out_ovf_q;
    ctrl         = '0;
    item_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        // every live cell compares against the wanted value at once
        ctrl.cmp = 1'b1;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (!reported_q) begin
            if (hit) begin
              reported_d   = 1'b1;
              out_valid_d  = 1'b1;
              out_found_d  = 1'b1;
              out_first_d  = sat_idx(hit_pos);
              out_second_d = sat_idx(count_q);
              out_ovf_d    = exceeded_q;
            end else begin
              if (count_q < CW'(STORE_DEPTH)) begin
                ctrl.shift = 1'b1;
                count_d    = count_q + CW'(1);
              end else begin
                exceeded_d = 1'b1;
              end
              if (last_q) begin
                out_valid_d  = 1'b1;
                out_found_d  = 1'b0;
                out_first_d  = '0;
                out_second_d = '0;
                out_ovf_d    = exceeded_d;
              end
            end
          end
          // set end clears the count and the set flags, but not the stored values
          if (last_q) begin
            count_d    = '0;
            reported_d = 1'b0;
            exceeded_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.found        = out_found_q;
  assign result_o.first_index  = out_first_q;
  assign result_o.second_index = out_second_q;
  assign result_o.overflow     = out_ovf_q;

  `PSS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(STORE_DEPTH), "store count past depth")
  `PSS_ASSERT_NOW(a_full_on_exceed, exceeded_q, count_q == CW'(STORE_DEPTH), "overflow before full")
  `PSS_ASSERT_NEXT(a_set_end_clear, state_q == ST_DECIDE && out_free && last_q, count_q == '0 && !reported_q && !exceeded_q, "set end left state behind")
  `PSS_ASSERT_NEXT(a_hit_marks, state_q == ST_DECIDE && out_free && !reported_q && hit && !last_q, reported_q && out_valid_q && out_found_q, "hit not reported")

endmodule

`default_nettype wire

FILE: rtl/pss_cell.sv
// one cell of the value chain: holds a stored value and compares it
`default_nettype none

module pss_cell import pss_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic                     live_i,
  input  wire logic [VAL_W-1:0]         din_i,
  input  wire logic signed [WANT_W-1:0] want_i,
  output logic [VAL_W-1:0]              dout_o,
  output logic                          match_o
);

  logic [VAL_W-1:0] value_q;
  logic             match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= din_i;
    end
  end

  // sign-extended compare against the 33-bit wanted value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= live_i && ($signed({value_q[VAL_W-1], value_q}) == want_i);
    end
  end

  assign dout_o  = value_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

FILE: rtl/pss_prio_enc.sv
// lowest-set-bit encoder over the cell match vector
`default_nettype none

module pss_prio_enc #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  wire logic [N-1:0] vec_i,
  output logic              hit_o,
  output logic [IW-1:0]     idx_o
);

  logic [N-1:0]  lowest;
  logic [IW-1:0] idx;

  always_comb begin
    lowest = vec_i & (~vec_i + N'(1));
    idx    = '0;
    for (int k = 0; k < N; k++) begin
      if (lowest[k]) begin
        idx = idx | IW'(k);
      end
    end
  end

  assign hit_o = |vec_i;
  assign idx_o = idx;

endmodule

`default_nettype wire

FILE: sim/pair_sum_search_stream_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the streaming pair sum search block
module pair_sum_search_stream_tb;
  import pss_pkg::*;

  localparam int DEPTH       = 64;
  localparam int MAX_GAP     = 17;
  // an item passes accept, compare and decide inside, plus a result parked in the output register
  localparam int SETTLE      = 12;
  localparam int RAND_ITEMS  = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int BURST_SETS  = 40;
  localparam int SETS_PER_PHASE = 25;
  localparam real LIMIT_NS   = 5_000_000.0;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             overflow;
  } pair_result_t;

  // shapes of a random set
  typedef enum int {
    SET_NEAR,   // values clustered around a pair, frequent hits and duplicates
    SET_NOISE,  // fully random values, hits are rare
    SET_LONG    // 60 to 75 values, may run past the store capacity
  } set_kind_e;

  // own model of the block: stored values of the current set and the pairs due
  class pair_sum_tracker;
    logic [VAL_W-1:0] target;
    logic [VAL_W-1:0] seen [DEPTH];
    int unsigned      seen_cnt;
    bit               reported;
    bit               over;
    pair_result_t     due_pairs [$];
    int unsigned      mismatches;

    function new();
      target     = '0;
      seen_cnt   = 0;
      reported   = 1'b0;
      over       = 1'b0;
      mismatches = 0;
    endfunction

    function logic [IDX_W-1:0] sat_index(int unsigned p);
      return (p > IDX_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(p);
    endfunction

    function void note_value(logic [VAL_W-1:0] value, logic last);
      logic signed [WANT_W-1:0] want;
      pair_result_t res;
      bit hit;
      int hit_pos;
      if (!reported) begin
        // exact 33 bit difference, no wrap
        want = $signed({target[VAL_W-1], target}) - $signed({value[VAL_W-1], value});
        hit = 1'b0;
        hit_pos = 0;
        // newest entry first, as an overwriting map would answer
        for (int i = int'(seen_cnt) - 1; i >= 0; i--) begin
          if (!hit && $signed({seen[i][VAL_W-1], seen[i]}) == want) begin
            hit = 1'b1;
            hit_pos = i;
          end
        end
        if (hit) begin
          reported = 1'b1;
          res.found        = 1'b1;
          res.first_index  = sat_index(hit_pos);
          res.second_index = sat_index(seen_cnt);
          res.overflow     = over;
          due_pairs.push_back(res);
        end else begin
          if (seen_cnt < DEPTH) begin
            seen[seen_cnt] = value;
            seen_cnt++;
          end else begin
            over = 1'b1;
          end
          if (last) begin
            res = '0;
            res.overflow = over;
            due_pairs.push_back(res);
          end
        end
      end
      if (last) begin
        seen_cnt = 0;
        reported = 1'b0;
        over     = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [IDX_W-1:0] want_v,
                                logic [IDX_W-1:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t exp;
      if (due_pairs.size() == 0) begin
        $display("%0t: unexpected result found %0b first %0d second %0d overflow %0b",
                 $time, got.found, got.first_index, got.second_index, got.overflow);
        mismatches++;
      end else begin
        exp = due_pairs.pop_front();
        compare_field("found", IDX_W'(exp.found), IDX_W'(got.found));
        compare_field("first_index", exp.first_index, got.first_index);
        compare_field("second_index", exp.second_index, got.second_index);
        compare_field("overflow", IDX_W'(exp.overflow), IDX_W'(got.overflow));
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             target_we = 1'b0;
  logic [VAL_W-1:0] target_val = '0;

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int hold_len = 0;

  pair_sum_tracker tracker = new();

  pss_in_if  item_if ();
  pss_out_if res_if ();

  pair_sum_search_stream #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_if),
    .result_o       (res_if),
    .target_sum_we_i(target_we),
    .target_sum_i   (target_val)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch both channels: results are checked, accepted values feed the model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        tracker.check_result({res_if.found, res_if.first_index,
                              res_if.second_index, res_if.overflow});
      end
      if (item_if.valid && item_if.ready) begin
        tracker.note_value(item_if.value, item_if.last);
      end
    end
  end

  // result side: random pause after each transfer, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    res_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          res_if.ready <= 1'b1;
        end
      end else if (hold_len > 0) begin
        // long hold-off, counted here while the sender keeps offering
        res_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        res_if.ready <= 1'b1;
      end
    end
  end

  // offer one value, returns at the edge of its transfer
  task automatic send_item(input logic [VAL_W-1:0] value, input logic last);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.value <= value;
    item_if.last  <= last;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
  endtask

  task automatic send_set(input logic [VAL_W-1:0] vals [$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // stop offering and let every due result arrive and the pipeline empty
  task automatic drain_results();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [VAL_W-1:0] value);
    target_we  <= 1'b1;
    target_val <= value;
    @(posedge clk_i);
    target_we  <= 1'b0;
    tracker.target = value;
  endtask

  task automatic random_set(output int n_items);
    logic [VAL_W-1:0] vals [$];
    logic [VAL_W-1:0] base;
    int pick, len, hi;
    set_kind_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 75) kind = SET_NEAR;
    else if (pick < 96) kind = SET_NOISE;
    else kind = SET_LONG;
    base = $urandom;
    case (kind)
      SET_NEAR: begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(0, 1) != 0) vals.push_back(base + $urandom_range(0, 3));
          else vals.push_back(tracker.target - base - $urandom_range(0, 3));
        end
      end
      SET_NOISE: begin
        len = $urandom_range(1, 8);
        repeat (len) vals.push_back($urandom);
      end
      default: begin
        len = $urandom_range(60, 75);
        repeat (len) vals.push_back($urandom);
        // half the time close the set with the partner of an early value
        if ($urandom_range(0, 1) != 0) begin
          hi = (len - 2 < DEPTH - 1) ? len - 2 : DEPTH - 1;
          vals[len-1] = tracker.target - vals[$urandom_range(0, hi)];
        end
      end
    endcase
    send_set(vals);
    n_items = len;
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0] vals [$];
    int sent, n, phase;
    item_if.valid = 1'b0;
    item_if.value = '0;
    item_if.last  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 1'b1;
    recv_idle = 1'b1;

    // largest positive target: pair at the top of the range
    write_target(32'h7fff_ffff);
    vals = {32'h7fff_ffff, 32'h0000_0000};
    send_set(vals);
    // difference of 2^32 - 1 must not alias to -1
    vals = {32'hffff_ffff, 32'h8000_0000};
    send_set(vals);

    drain_results();
    write_target(32'h8000_0000);
    // hit, then a trailing value with last is absorbed
    vals = {32'h8000_0000, 32'h0000_0000, 32'h0000_0005};
    send_set(vals);
    // single value set, no pair
    vals = {32'h7fff_ffff};
    send_set(vals);

    drain_results();
    write_target(32'd10);
    // duplicates: the newest copy of 3 is reported
    vals = {32'd3, 32'd3, 32'd4, 32'd7};
    send_set(vals);
    // hit value is not stored, the rest is absorbed
    vals = {32'd6, 32'd4, 32'd4};
    send_set(vals);
    // no pair at the set end
    vals = {32'd1, 32'd2};
    send_set(vals);
    // store full: two values dropped, then a hit on the first one
    vals = {};
    for (int i = 0; i < DEPTH + 2; i++) vals.push_back(32'd100 + 2 * i);
    vals.push_back(32'd10 - 32'd100);
    send_set(vals);

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      drain_results();
      case (phase)
        0:       write_target('0);
        1:       write_target('1);
        default: write_target($urandom);
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // one result per value while the sink holds off: the block backs up
        hold_len  = HOLD_CYCLES;
        send_idle = 1'b0;
        repeat (BURST_SETS) send_item($urandom, 1'b1);
        sent += BURST_SETS;
        // sender waits for every result before going on
        drain_results();
        send_idle = 1'b1;
      end
      repeat (SETS_PER_PHASE) begin
        random_set(n);
        sent += n;
      end
      phase++;
    end

    drain_results();
    if (tracker.mismatches == 0 && tracker.due_pairs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
